[src/wstq_pkg.sv]
// Package for the work-stealing task queues: operation and status codes,
// controller state type and the controller-to-datapath command bundle.
// No dependencies.
package wstq_pkg;

  // Operation codes carried by the kind field of an item.
  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_STEAL = 2'd2;

  // Result status codes.
  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_EMPTY  = 2'd1;
  localparam logic [1:0] STS_FULL   = 2'd2;
  localparam logic [1:0] STS_BADWKR = 2'd3;

  // Active worker count after reset.
  localparam logic [3:0] ACTIVE_RESET = 4'd8;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_ACCESS,
    S_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the accepted item
    logic decide;   // pick the target deque and status
    logic access;   // touch the task memory and the counters
    logic respond;  // present the result
  } dp_cmd_t;

endpackage

[src/work_stealing_task_queues.sv]
// Work-stealing task queues: one bounded task deque per worker with push,
// pop and round-robin steal. Top level; depends on wstq_pkg, wstq_ctrl,
// wstq_dp and wstq_ram.
//
// An item is accepted when start is high and busy is low. Its result appears
// for one cycle with out_valid after the item's search and access steps; the
// receiver cannot stall it. A new item is taken in the same cycle that a
// result shows, but none during the search and access of an item. The
// three steps are victim search over the per-worker counters, one access to
// the task memory, whose read port is registered, and the response.
// active_workers is register 0 at byte address 0 of the APB port.
module work_stealing_task_queues import wstq_pkg::*; #(
  parameter int NUM_WORKERS = 8,
  parameter int DEQUE_DEPTH = 16,
  parameter int TASK_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [2:0]  in_worker,
  input  logic [31:0] in_task_value,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_task_out,
  output logic [2:0]  out_victim,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  dp_cmd_t    cmd;
  logic       cfg_we;
  logic [3:0] active_workers;

  // Configuration port: one register at word address zero.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : 32'(active_workers);

  wstq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  wstq_dp #(
    .NUM_WORKERS (NUM_WORKERS),
    .DEQUE_DEPTH (DEQUE_DEPTH),
    .TASK_WIDTH  (TASK_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_kind        (in_kind),
    .in_worker      (in_worker),
    .in_task_value  (in_task_value),
    .cfg_we         (cfg_we),
    .cfg_wdata      (pwdata[3:0]),
    .active_workers (active_workers),
    .out_status     (out_status),
    .out_task_out   (out_task_out),
    .out_victim     (out_victim)
  );

  assign out_valid = cmd.respond;

  // An accepted item blocks the next one during its search and access.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an item was accepted");

  // Every accepted item yields its result after its search and access steps.
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("result missing three cycles after accept");

  // A rejected worker never carries a task or a victim.
  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STS_BADWKR)) |-> (out_task_out == 32'd0 && out_victim == 3'd0))
    else $error("bad-worker result carries data");

endmodule

[src/wstq_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module wstq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/wstq_ctrl.sv]
// Controller for the work-stealing task queues: sequences each item through
// search, memory access and response. Depends on wstq_pkg.
module wstq_ctrl import wstq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   accept;

  // The block takes an item when idle or while the previous result shows.
  assign busy   = (state_r == S_SEARCH) || (state_r == S_ACCESS);
  assign accept = start && !busy;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   state_nxt = accept ? S_SEARCH : S_IDLE;
      S_SEARCH: state_nxt = S_ACCESS;
      S_ACCESS: state_nxt = S_RESP;
      S_RESP:   state_nxt = accept ? S_SEARCH : S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd.load    = accept;
    cmd.decide  = 1'b0;
    cmd.access  = 1'b0;
    cmd.respond = 1'b0;
    case (state_r)
      S_SEARCH: cmd.decide  = 1'b1;
      S_ACCESS: cmd.access  = 1'b1;
      S_RESP:   cmd.respond = 1'b1;
      default:  ;
    endcase
  end

endmodule

[src/wstq_dp.sv]
// Datapath for the work-stealing task queues: item registers, per-worker
// counters, round-robin victim search and the task memory.
// Depends on wstq_pkg and wstq_ram.
module wstq_dp import wstq_pkg::*; #(
  parameter int NUM_WORKERS = 8,
  parameter int DEQUE_DEPTH = 16,
  parameter int TASK_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  input  logic [1:0]  in_kind,
  input  logic [2:0]  in_worker,
  input  logic [31:0] in_task_value,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  output logic [3:0]  active_workers,
  output logic [1:0]  out_status,
  output logic [31:0] out_task_out,
  output logic [2:0]  out_victim
);

  localparam int WIDX = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int CW   = $clog2(DEQUE_DEPTH + 1);
  localparam int FW   = $clog2(DEQUE_DEPTH);
  localparam int PW   = CW + 1;
  localparam int MD   = NUM_WORKERS * DEQUE_DEPTH;
  localparam int AW   = $clog2(MD);

  // Item and configuration registers.
  logic [1:0]  kind_r;
  logic [2:0]  worker_r;
  logic [31:0] task_r;
  logic [3:0]  active_r;

  // Per-worker deque bookkeeping.
  logic [CW-1:0] count_r [NUM_WORKERS];
  logic [FW-1:0] front_r [NUM_WORKERS];

  // Decision registers.
  logic [WIDX-1:0] tgt_r, tgt_nxt;
  logic [1:0]      status_r, status_nxt;
  logic [2:0]      victim_r, victim_nxt;
  logic            take_r, take_nxt;

  logic [3:0]             n_act;
  logic [NUM_WORKERS-1:0] ne, full;
  logic [7:0]             w_ext;
  logic [WIDX-1:0]        wi;
  logic                   hi_found, lo_found;
  logic [WIDX-1:0]        hi_idx, lo_idx;
  logic [7:0]             tgt_ext;

  logic [CW-1:0]    cnt, offset;
  logic [FW-1:0]    fr;
  logic [PW-1:0]    pos_raw, pos;
  logic [AW-1:0]    addr;
  logic             acc_ok, mem_we;
  logic [63:0]      task_ext, rd_ext;
  logic [TASK_WIDTH-1:0] mem_rdata;

  assign active_workers = active_r;

  // Capture the item on accept; configuration writes.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_kind;
      worker_r <= in_worker;
      task_r   <= in_task_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
    end else if (cfg_we) begin
      active_r <= cfg_wdata;
    end
  end

  // Effective active count, clamped to one and to the number of deques.
  always_comb begin
    if (active_r == 4'd0) begin
      n_act = 4'd1;
    end else if (int'(active_r) > NUM_WORKERS) begin
      n_act = 4'(NUM_WORKERS);
    end else begin
      n_act = active_r;
    end
  end

  // Empty and full flags of every deque.
  always_comb begin
    for (int j = 0; j < NUM_WORKERS; j++) begin
      ne[j]   = (count_r[j] != '0);
      full[j] = (count_r[j] == CW'(DEQUE_DEPTH));
    end
  end

  assign w_ext = 8'(worker_r);
  assign wi    = w_ext[WIDX-1:0];

  // Round-robin search: lowest non-empty worker above the requester,
  // otherwise lowest non-empty worker below it.
  always_comb begin
    hi_found = 1'b0;
    lo_found = 1'b0;
    hi_idx   = '0;
    lo_idx   = '0;
    for (int j = NUM_WORKERS - 1; j >= 0; j--) begin
      if (ne[j] && (j < int'(n_act))) begin
        if (j > int'(worker_r)) begin
          hi_found = 1'b1;
          hi_idx   = WIDX'(j);
        end else if (j < int'(worker_r)) begin
          lo_found = 1'b1;
          lo_idx   = WIDX'(j);
        end
      end
    end
  end

  // Target deque and status of the item.
  always_comb begin
    tgt_nxt    = '0;
    status_nxt = STS_EMPTY;
    take_nxt   = 1'b0;
    if ({1'b0, worker_r} >= n_act) begin
      status_nxt = STS_BADWKR;
    end else begin
      case (kind_r)
        KIND_PUSH: begin
          tgt_nxt    = wi;
          status_nxt = full[wi] ? STS_FULL : STS_OK;
        end
        KIND_POP: begin
          tgt_nxt = wi;
          if (ne[wi]) begin
            status_nxt = STS_OK;
            take_nxt   = 1'b1;
          end
        end
        KIND_STEAL: begin
          if (hi_found || lo_found) begin
            tgt_nxt    = hi_found ? hi_idx : lo_idx;
            status_nxt = STS_OK;
            take_nxt   = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign tgt_ext    = 8'(tgt_nxt);
  assign victim_nxt = take_nxt ? tgt_ext[2:0] : 3'd0;

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      tgt_r    <= tgt_nxt;
      status_r <= status_nxt;
      victim_r <= victim_nxt;
      take_r   <= take_nxt;
    end
  end

  // Ring slot of the entry that the item touches.
  assign cnt    = count_r[tgt_r];
  assign fr     = front_r[tgt_r];
  assign acc_ok = cmd.access && (status_r == STS_OK);

  always_comb begin
    case (kind_r)
      KIND_PUSH: offset = cnt;
      KIND_POP:  offset = cnt - CW'(1);
      default:   offset = '0;
    endcase
  end

  assign pos_raw = PW'(fr) + PW'(offset);
  assign pos     = (pos_raw >= PW'(DEQUE_DEPTH)) ? pos_raw - PW'(DEQUE_DEPTH) : pos_raw;
  assign addr    = AW'(tgt_r) * AW'(DEQUE_DEPTH) + AW'(pos);
  assign mem_we  = acc_ok && (kind_r == KIND_PUSH);

  // Counter and front updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NUM_WORKERS; j++) begin
        count_r[j] <= '0;
        front_r[j] <= '0;
      end
    end else if (acc_ok) begin
      case (kind_r)
        KIND_PUSH: count_r[tgt_r] <= cnt + CW'(1);
        KIND_POP:  count_r[tgt_r] <= cnt - CW'(1);
        KIND_STEAL: begin
          count_r[tgt_r] <= cnt - CW'(1);
          front_r[tgt_r] <= (fr == FW'(DEQUE_DEPTH - 1)) ? '0 : fr + FW'(1);
        end
        default: ;
      endcase
    end
  end

  // Task memory.
  assign task_ext = 64'(task_r);

  wstq_ram #(
    .WIDTH (TASK_WIDTH),
    .DEPTH (MD)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (addr),
    .wdata (task_ext[TASK_WIDTH-1:0]),
    .re    (cmd.access),
    .raddr (addr),
    .rdata (mem_rdata)
  );

  // Result.
  assign rd_ext       = 64'(mem_rdata);
  assign out_status   = status_r;
  assign out_task_out = take_r ? rd_ext[31:0] : 32'd0;
  assign out_victim   = victim_r;

endmodule

[bench/testbench.sv]
// Self-checking testbench for work_stealing_task_queues: directed table, then random traffic.
// A local model of the per-worker deques predicts every result. Depends on wstq_pkg and the
// block itself.
module testbench;
  import wstq_pkg::*;

  localparam int NUM_WORKERS = 8;
  localparam int DEQUE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [2:0] ADDR_ACTIVE = 3'd0;
  localparam int SEGMENTS = 9;
  localparam int SEGMENT_ITEMS = 135;
  localparam int PENDING_DEPTH = 8;

  // One result of the block.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] task_out;
    logic [2:0]  victim;
  } outcome_t;

  // One row of the directed table: either an item or a write of active_workers.
  typedef enum logic {ROW_ITEM, ROW_CFG} row_t;
  typedef struct packed {
    row_t        row;
    logic [3:0]  cfg_value;
    logic [1:0]  kind;
    logic [2:0]  wkr;
    logic [31:0] word;
    logic        typed;
    outcome_t    want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_kind = KIND_PUSH;
  logic [2:0]  in_worker = 3'd0;
  logic [31:0] in_task_value = 32'd0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_task_out;
  logic [2:0]  out_victim;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Local copy of the deques and of the active_workers register.
  logic [31:0] deque_words [NUM_WORKERS][DEQUE_DEPTH];
  logic [3:0]  deque_front [NUM_WORKERS];
  logic [4:0]  deque_fill [NUM_WORKERS];
  logic [3:0]  workers_reg;

  // Expected results in order, kept in a small ring with running write and read counts.
  outcome_t pending_ring [PENDING_DEPTH];
  int pending_wr = 0;
  int pending_rd = 0;
  int mismatch_count = 0;
  int items_issued = 0;
  int outcomes_seen = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int cycle_count = 0;

  plan_row_t plan [0:23];
  logic [3:0] seg_workers [0:SEGMENTS-1] = '{4'd8, 4'd5, 4'd1, 4'd12, 4'd8, 4'd2, 4'd0, 4'd7,
                                              4'd8};

  work_stealing_task_queues #(
    .NUM_WORKERS(NUM_WORKERS),
    .DEQUE_DEPTH(DEQUE_DEPTH),
    .TASK_WIDTH(32)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_kind(in_kind),
    .in_worker(in_worker),
    .in_task_value(in_task_value),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_task_out(out_task_out),
    .out_victim(out_victim),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Number of deques in use; zero acts as one and values above the worker count saturate.
  function automatic int active_span();
    if (workers_reg == 4'd0) return 1;
    if (workers_reg > NUM_WORKERS) return NUM_WORKERS;
    return int'(workers_reg);
  endfunction

  // Applies one item to the local deques and returns the result it should produce.
  function automatic outcome_t deque_apply(logic [1:0] kind, logic [2:0] wkr,
                                           logic [31:0] word);
    outcome_t r;
    int n;
    int v;
    r = '{STS_EMPTY, 32'd0, 3'd0};
    n = active_span();
    if (wkr >= n) begin
      r.status = STS_BADWKR;
    end else if (kind == KIND_PUSH) begin
      if (deque_fill[wkr] >= DEQUE_DEPTH) begin
        r.status = STS_FULL;
      end else begin
        deque_words[wkr][(deque_front[wkr] + deque_fill[wkr]) % DEQUE_DEPTH] = word;
        deque_fill[wkr] = deque_fill[wkr] + 5'd1;
        r.status = STS_OK;
      end
    end else if (kind == KIND_POP) begin
      if (deque_fill[wkr] != 0) begin
        r.task_out = deque_words[wkr][(deque_front[wkr] + deque_fill[wkr] - 1) % DEQUE_DEPTH];
        deque_fill[wkr] = deque_fill[wkr] - 5'd1;
        r.victim = wkr;
        r.status = STS_OK;
      end
    end else if (kind == KIND_STEAL) begin
      // Round-robin search over the other active workers, starting after the requester.
      for (int i = 0; i + 1 < n; i++) begin
        v = (wkr + 1 + i) % n;
        if (deque_fill[v] != 0) begin
          r.task_out = deque_words[v][deque_front[v]];
          deque_front[v] = 4'((deque_front[v] + 1) % DEQUE_DEPTH);
          deque_fill[v] = deque_fill[v] - 5'd1;
          r.victim = 3'(v);
          r.status = STS_OK;
          break;
        end
      end
    end
    return r;
  endfunction

  // Presents one item and holds it until the block takes it, then records the outcome.
  task automatic issue(input logic [1:0] kind, input logic [2:0] wkr, input logic [31:0] word,
                       input logic typed, input outcome_t want);
    outcome_t predicted;
    start <= 1'b1;
    in_kind <= kind;
    in_worker <= wkr;
    in_task_value <= word;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = deque_apply(kind, wkr, word);
    pending_ring[pending_wr % PENDING_DEPTH] = typed ? want : predicted;
    pending_wr++;
    items_issued++;
  endtask

  // Random sender idling: each cycle idles with the given chance in a hundred.
  task automatic sender_gap(input int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < pct);
    end
  endtask

  // Stops sending and waits until every outstanding result has come back.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending_wr != pending_rd);
    repeat (4) @(posedge clk);
  endtask

  // APB write of active_workers with random upper data bits, which the register ignores.
  // The register is read back once the write has landed.
  task automatic write_workers(input logic [3:0] value);
    logic [31:0] word;
    word = $urandom();
    word[3:0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_ACTIVE;
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    workers_reg = value;
    @(posedge clk);
    if (prdata !== 32'(value)) begin
      $error("prdata: expected %0d, got %0d", value, prdata);
      mismatch_count++;
    end
  endtask

  // Result checker: every strobed result is matched against the oldest expected one.
  always @(posedge clk) begin : check_outcome
    outcome_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_wr == pending_rd) begin
        $error("result with no item outstanding: status %0d task_out %h victim %0d",
               out_status, out_task_out, out_victim);
        mismatch_count++;
      end else begin
        want = pending_ring[pending_rd % PENDING_DEPTH];
        pending_rd++;
        outcomes_seen++;
        status_seen[want.status]++;
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatch_count++;
        end
        if (out_task_out !== want.task_out) begin
          $error("task_out: expected %h, got %h", want.task_out, out_task_out);
          mismatch_count++;
        end
        if (out_victim !== want.victim) begin
          $error("victim: expected %0d, got %0d", want.victim, out_victim);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin : stimulus
    int seg;
    int k;
    int pick;
    int span;
    int idle_pct;
    logic [2:0] hot;
    logic [2:0] wkr;
    logic [1:0] kind;

    // Directed table. Rows with typed=1 carry a hand-written result; the rest use the model.
    plan = '{
      '{ROW_ITEM, 4'd0,  KIND_POP,    3'd0, 32'h0,        1'b1, '{STS_EMPTY,  32'h0, 3'd0}},
      '{ROW_ITEM, 4'd0,  KIND_STEAL,  3'd3, 32'h0,        1'b1, '{STS_EMPTY,  32'h0, 3'd0}},
      '{ROW_ITEM, 4'd0,  KIND_UNUSED, 3'd5, 32'hDEADBEEF, 1'b1, '{STS_EMPTY,  32'h0, 3'd0}},
      '{ROW_ITEM, 4'd0,  KIND_PUSH,   3'd7, 32'hFFFFFFFF, 1'b1, '{STS_OK,     32'h0, 3'd0}},
      '{ROW_ITEM, 4'd0,  KIND_PUSH,   3'd0, 32'h00000000, 1'b1, '{STS_OK,     32'h0, 3'd0}},
      '{ROW_ITEM, 4'd0,  KIND_PUSH,   3'd0, 32'hA5A5A5A5, 1'b1, '{STS_OK,     32'h0, 3'd0}},
      '{ROW_ITEM, 4'd0,  KIND_POP,    3'd0, 32'h0,        1'b0, '0},
      '{ROW_ITEM, 4'd0,  KIND_STEAL,  3'd7, 32'h0,        1'b0, '0},
      '{ROW_ITEM, 4'd0,  KIND_STEAL,  3'd6, 32'hFFFFFFFF, 1'b0, '0},
      '{ROW_CFG,  4'd1,  KIND_PUSH,   3'd0, 32'h0,        1'b0, '0},
      '{ROW_ITEM, 4'd0,  KIND_PUSH,   3'd0, 32'h5A5A5A5A, 1'b1, '{STS_OK,     32'h0, 3'd0}},
      '{ROW_ITEM, 4'd0,  KIND_STEAL,  3'd0, 32'h0,        1'b1, '{STS_EMPTY,  32'h0, 3'd0}},
      '{ROW_ITEM, 4'd0,  KIND_PUSH,   3'd1, 32'h11111111, 1'b1, '{STS_BADWKR, 32'h0, 3'd0}},
      '{ROW_ITEM, 4'd0,  KIND_POP,    3'd7, 32'h0,        1'b1, '{STS_BADWKR, 32'h0, 3'd0}},
      '{ROW_CFG,  4'd0,  KIND_PUSH,   3'd0, 32'h0,        1'b0, '0},
      '{ROW_ITEM, 4'd0,  KIND_POP,    3'd3, 32'h0,        1'b1, '{STS_BADWKR, 32'h0, 3'd0}},
      '{ROW_ITEM, 4'd0,  KIND_POP,    3'd0, 32'h0,        1'b0, '0},
      '{ROW_CFG,  4'd15, KIND_PUSH,   3'd0, 32'h0,        1'b0, '0},
      '{ROW_ITEM, 4'd0,  KIND_PUSH,   3'd3, 32'h12345678, 1'b1, '{STS_OK,     32'h0, 3'd0}},
      '{ROW_ITEM, 4'd0,  KIND_STEAL,  3'd7, 32'h0,        1'b0, '0},
      '{ROW_CFG,  4'd3,  KIND_PUSH,   3'd0, 32'h0,        1'b0, '0},
      '{ROW_ITEM, 4'd0,  KIND_PUSH,   3'd5, 32'h87654321, 1'b1, '{STS_BADWKR, 32'h0, 3'd0}},
      '{ROW_ITEM, 4'd0,  KIND_STEAL,  3'd2, 32'h0,        1'b0, '0},
      '{ROW_ITEM, 4'd0,  KIND_POP,    3'd1, 32'h0,        1'b1, '{STS_EMPTY,  32'h0, 3'd0}}
    };

    // Model state after reset.
    for (int w = 0; w < NUM_WORKERS; w++) begin
      deque_front[w] = 4'd0;
      deque_fill[w] = 5'd0;
      for (int s = 0; s < DEQUE_DEPTH; s++) deque_words[w][s] = 32'd0;
    end
    workers_reg = ACTIVE_RESET;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[r]) begin
      if (plan[r].row == ROW_CFG) begin
        settle();
        write_workers(plan[r].cfg_value);
      end else begin
        issue(plan[r].kind, plan[r].wkr, plan[r].word, plan[r].typed, plan[r].want);
      end
    end

    // Random segments: each fills a favored worker's deque, then drains the deques.
    // Sender idling is heavy-ish, then very heavy, then absent.
    for (seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      write_workers(seg_workers[seg]);
      idle_pct = (seg < 3) ? 27 : ((seg < 6) ? 85 : 0);
      span = active_span();
      hot = 3'($urandom_range(0, span - 1));
      for (k = 0; k < SEGMENT_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (k < SEGMENT_ITEMS / 2) begin
          kind = (pick < 60) ? KIND_PUSH : (pick < 75) ? KIND_POP :
                 (pick < 95) ? KIND_STEAL : KIND_UNUSED;
        end else begin
          kind = (pick < 25) ? KIND_PUSH : (pick < 60) ? KIND_POP :
                 (pick < 95) ? KIND_STEAL : KIND_UNUSED;
        end
        pick = $urandom_range(0, 9);
        if (pick < 5) wkr = hot;
        else if (pick < 9) wkr = 3'($urandom_range(0, span - 1));
        else wkr = 3'($urandom_range(0, NUM_WORKERS - 1));
        // Now and then let everything drain before the next item.
        if ($urandom_range(0, 59) == 0) settle();
        else sender_gap(idle_pct);
        issue(kind, wkr, $urandom(), 1'b0, '0);
      end
    end

    settle();
    $display("testbench: %0d items sent over %0d worker settings, %0d results checked",
             items_issued, SEGMENTS + 5, outcomes_seen);
    $display("testbench: status ok %0d, empty %0d, full %0d, worker out of range %0d",
             status_seen[STS_OK], status_seen[STS_EMPTY], status_seen[STS_FULL],
             status_seen[STS_BADWKR]);
    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
src/wstq_pkg.sv
src/wstq_ram.sv
src/wstq_ctrl.sv
src/wstq_dp.sv
src/work_stealing_task_queues.sv
bench/testbench.sv
